// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque core.
// No dependencies; every other file of the block imports this package.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_BACK  = 3'd5,
        MODE_CLEAR      = 3'd6
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DATA  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_FULL  = 2'd3
    } t_status;

    // Per-cycle command to one chain of cells.
    typedef struct packed {
        logic shift_up;    // insert at cell 0, every cell takes its lower neighbor
        logic shift_down;  // drop cell 0, every cell takes its upper neighbor
        logic append;      // the cell whose index equals the count takes the value
    } t_chain_ctl;

endpackage

// ===== hw/rtl/bdq_if.sv =====
// Valid/ready channel interfaces for the bounded deque core.
// Depends on bdq_pkg for field widths.
interface bdq_in_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_FIELD_W-1:0] count;

    modport source (output valid, output status, output data_out, output count, input ready);
    modport sink   (input valid, input status, input data_out, input count, output ready);
endinterface

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of a deque chain: holds one element and trades it with its neighbors.
// Depends on bdq_pkg for t_chain_ctl and DATA_W.
module bdq_cell import bdq_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 11
) (
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_lower,
    input  logic [DATA_W-1:0] i_upper,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_is_tail_slot;

    assign w_is_tail_slot = (i_count == CNT_W'(IDX));

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            n_data = i_lower;
        end else if (i_ctl.shift_down) begin
            n_data = i_upper;
        end else if (i_ctl.append && w_is_tail_slot) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/bdq_chain.sv =====
// Row of deque cells with the end element at cell 0.
// Depends on bdq_pkg and bdq_cell.
module bdq_chain import bdq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_value,
    output logic [DATA_W-1:0] o_head
);

    logic [DATA_W-1:0] w_data  [DEPTH];
    logic [DATA_W-1:0] w_lower [DEPTH];
    logic [DATA_W-1:0] w_upper [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_lower[g] = i_value;
        end else begin : g_mid_lo
            assign w_lower[g] = w_data[g-1];
        end

        // The last cell holds on a downward shift; its content is past the count anyway.
        if (g == DEPTH - 1) begin : g_last
            assign w_upper[g] = w_data[g];
        end else begin : g_mid_hi
            assign w_upper[g] = w_data[g+1];
        end

        bdq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_value (i_value),
            .i_lower (w_lower[g]),
            .i_upper (w_upper[g]),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// ===== hw/rtl/bounded_deque_with_error_flags_core.sv =====
// Top level of the bounded deque: command decode, count, output register, two cell chains.
// Depends on bdq_pkg, bdq_if (bdq_in_if, bdq_out_if) and bdq_chain.
//
//  channel | dir | payload                        | transfer when
//  --------+-----+--------------------------------+----------------------
//  i_cmd   | in  | mode, push_value               | valid && ready
//  o_rsp   | out | status, data_out, count        | valid && ready
//
// One command per cycle while i_cmd.ready is high; its result appears in the output register on the next cycle.
// Two chains of DEPTH cells hold the same contents in opposite order, so both the
// front and the back element sit at a fixed cell and no operation needs more than one shift.
// i_cmd.ready is high while the output register is empty or being drained.
// Reset clears the count and the output valid; cell contents need no reset.
module bounded_deque_with_error_flags_core import bdq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdq_in_if.sink       i_cmd,
    bdq_out_if.source    o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

    logic                r_out_valid;
    t_status             r_status;
    logic [DATA_W-1:0]   r_data;
    logic [CNT_W-1:0]    r_count;

    t_status             n_status;
    logic [DATA_W-1:0]   n_data;
    logic [CNT_W-1:0]    n_count;

    t_chain_ctl          w_ctl_front;
    t_chain_ctl          w_ctl_back;
    logic [DATA_W-1:0]   w_front_head;
    logic [DATA_W-1:0]   w_back_head;
    logic                w_accept;
    logic                w_empty;
    logic                w_full;
    t_mode               w_mode;
    logic [EXT_W-1:0]    w_count_ext;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_mode      = t_mode'(i_cmd.mode);

    always_comb begin
        n_status    = STATUS_OK;
        n_data      = '0;
        n_count     = r_count;
        w_ctl_front = '0;
        w_ctl_back  = '0;
        case (w_mode)
            MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_ctl_front.shift_up = 1'b1;
                    w_ctl_back.append    = 1'b1;
                    n_count              = r_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_ctl_back.shift_up = 1'b1;
                    w_ctl_front.append  = 1'b1;
                    n_count             = r_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_status = STATUS_DATA;
                    n_data   = w_front_head;
                    if (w_mode == MODE_POP_FRONT) begin
                        // back chain just loses its tail through the count
                        w_ctl_front.shift_down = 1'b1;
                        n_count                = r_count - 1'b1;
                    end
                end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_status = STATUS_DATA;
                    n_data   = w_back_head;
                    if (w_mode == MODE_POP_BACK) begin
                        w_ctl_back.shift_down = 1'b1;
                        n_count               = r_count - 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused mode code: report ok, change nothing
            end
        endcase

        if (!w_accept) begin
            w_ctl_front = '0;
            w_ctl_back  = '0;
        end
    end

    bdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_front),
        .i_count (r_count),
        .i_value (i_cmd.push_value),
        .o_head  (w_front_head)
    );

    bdq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_back),
        .i_count (r_count),
        .i_value (i_cmd.push_value),
        .o_head  (w_back_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next accepted command.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign w_count_ext = EXT_W'(r_count);

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.data_out = r_data;
    assign o_rsp.count    = w_count_ext[COUNT_FIELD_W-1:0];

endmodule

// ===== test/tb_bounded_deque_with_error_flags_core.sv =====
// Self-checking bench for bounded_deque_with_error_flags_core: a directed table, then random traffic.
// Depends on bdq_pkg and on the bdq_in_if / bdq_out_if channel interfaces.
`timescale 1ns / 100ps

module tb_bounded_deque_with_error_flags_core;
    import bdq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 3000;
    localparam int PRINT_CAP  = 200;

    localparam logic [MODE_W-1:0]        MODE_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'sh8000_0000;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [COUNT_FIELD_W-1:0] count;
    } t_deque_result;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        t_deque_result            want;
    } t_stim_row;

    localparam int N_ROWS = 25;

    // Rows with typed=1 carry a hand-written result; the rest go through the predictor.
    t_stim_row dir_rows [N_ROWS] = '{
        '{MODE_POP_FRONT,  32'sh1234_5678, 1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_POP_BACK,   32'sh1234_5678, 1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_PEEK_FRONT, VAL_MAX,        1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_PEEK_BACK,  VAL_MIN,        1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_UNUSED,     32'sd0,         1'b1, '{STATUS_OK,    32'sd0, 11'd0}},
        '{MODE_CLEAR,      -32'sd1,        1'b1, '{STATUS_OK,    32'sd0, 11'd0}},
        '{MODE_PUSH_FRONT, VAL_MAX,        1'b1, '{STATUS_OK,    32'sd0, 11'd1}},
        '{MODE_PUSH_BACK,  VAL_MIN,        1'b1, '{STATUS_OK,    32'sd0, 11'd2}},
        '{MODE_PUSH_FRONT, -32'sd1,        1'b1, '{STATUS_OK,    32'sd0, 11'd3}},
        '{MODE_PEEK_FRONT, 32'sd0,         1'b1, '{STATUS_DATA,  -32'sd1, 11'd3}},
        '{MODE_PEEK_BACK,  32'sd0,         1'b1, '{STATUS_DATA,  VAL_MIN, 11'd3}},
        '{MODE_UNUSED,     VAL_MAX,        1'b1, '{STATUS_OK,    32'sd0, 11'd3}},
        '{MODE_POP_BACK,   32'sd0,         1'b1, '{STATUS_DATA,  VAL_MIN, 11'd2}},
        '{MODE_POP_FRONT,  32'sd0,         1'b1, '{STATUS_DATA,  -32'sd1, 11'd1}},
        '{MODE_POP_FRONT,  32'sd0,         1'b1, '{STATUS_DATA,  VAL_MAX, 11'd0}},
        '{MODE_POP_FRONT,  32'sd0,         1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_PUSH_BACK,  32'sd0,         1'b1, '{STATUS_OK,    32'sd0, 11'd1}},
        '{MODE_PUSH_BACK,  32'sd1,         1'b1, '{STATUS_OK,    32'sd0, 11'd2}},
        '{MODE_PEEK_BACK,  32'sd0,         1'b1, '{STATUS_DATA,  32'sd1, 11'd2}},
        '{MODE_CLEAR,      32'sd0,         1'b1, '{STATUS_OK,    32'sd0, 11'd0}},
        '{MODE_PEEK_FRONT, 32'sd0,         1'b1, '{STATUS_EMPTY, 32'sd0, 11'd0}},
        '{MODE_PUSH_BACK,  32'sh5555_5555, 1'b1, '{STATUS_OK,    32'sd0, 11'd1}},
        '{MODE_PUSH_FRONT, 32'shAAAA_AAAA, 1'b1, '{STATUS_OK,    32'sd0, 11'd2}},
        '{MODE_POP_BACK,   32'sd0,         1'b0, '{STATUS_OK,    32'sd0, 11'd0}},
        '{MODE_POP_BACK,   32'sd0,         1'b0, '{STATUS_OK,    32'sd0, 11'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    bdq_in_if  cmd_ch ();
    bdq_out_if rsp_ch ();

    bounded_deque_with_error_flags_core #(.DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted deque contents
    logic signed [DATA_W-1:0] slot_copy [DEPTH];
    int unsigned              head_copy;
    int unsigned              fill_copy;

    t_deque_result expected_q [$];
    t_stim_row     offered;
    int            mismatches;
    int            results_seen;
    int            idle_cycles;
    int            burst_left;
    int            gen_fill;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deque_result deque_apply(input logic [MODE_W-1:0] m,
                                                  input logic signed [DATA_W-1:0] v);
        t_deque_result r;
        int unsigned   spot;
        r.status = STATUS_OK;
        r.data   = '0;
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (fill_copy >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (m == MODE_PUSH_FRONT) begin
                        head_copy = (head_copy + DEPTH - 1) % DEPTH;
                        slot_copy[head_copy] = v;
                    end else begin
                        slot_copy[(head_copy + fill_copy) % DEPTH] = v;
                    end
                    fill_copy++;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                if (fill_copy == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    if (m == MODE_POP_BACK || m == MODE_PEEK_BACK)
                        spot = (head_copy + fill_copy - 1) % DEPTH;
                    else
                        spot = head_copy;
                    r.data   = slot_copy[spot];
                    r.status = STATUS_DATA;
                    if (m == MODE_POP_FRONT) begin
                        head_copy = (head_copy + 1) % DEPTH;
                        fill_copy--;
                    end else if (m == MODE_POP_BACK) begin
                        fill_copy--;
                    end
                end
            end
            MODE_CLEAR: begin
                head_copy = 0;
                fill_copy = 0;
            end
            default: ;  // unused mode: no effect
        endcase
        r.count = COUNT_FIELD_W'(fill_copy);
        return r;
    endfunction

    // Element count the stream will have after m, tracked at generation time.
    function automatic int fill_after(input logic [MODE_W-1:0] m, input int f);
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: return (f < DEPTH) ? f + 1 : f;
            MODE_POP_FRONT, MODE_POP_BACK:   return (f > 0) ? f - 1 : f;
            MODE_CLEAR:                      return 0;
            default:                         return f;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int push_pct, input int pop_pct,
                                                    input int clear_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
        if (r < push_pct + pop_pct + clear_pct)
            return MODE_CLEAR;
        if ($urandom_range(0, 9) == 0)
            return MODE_UNUSED;
        return $urandom_range(0, 1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one item, with bursts and random gaps, and hold it until the transfer.
    task automatic send_item(input t_stim_row row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
        end
        burst_left--;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= row.mode;
        cmd_ch.push_value <= row.value;
        offered           <= row;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        gen_fill = fill_after(row.mode, gen_fill);
    endtask

    task automatic send_random(input logic [MODE_W-1:0] m);
        t_stim_row row;
        row.mode  = m;
        row.value = pick_value();
        row.typed = 1'b0;
        row.want  = '0;
        send_item(row);
    endtask

    task automatic run_mix(input int n, input int push_pct, input int pop_pct,
                           input int clear_pct);
        repeat (n) send_random(pick_mode(push_pct, pop_pct, clear_pct));
    endtask

    // Predict on every input transfer, check on every output transfer.
    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result pred;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                pred = deque_apply(cmd_ch.mode, cmd_ch.push_value);
                expected_q.insert(expected_q.size(), offered.typed ? offered.want : pred);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.data_out !== want.data)
                        report_mismatch($sformatf("data_out got %h want %h",
                                                  rsp_ch.data_out, want.data));
                    if (rsp_ch.count !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  rsp_ch.count, want.count));
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TIMEOUT after %0d cycles without a transfer", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: stall phases of varying density, plus one long hold-off.
    initial begin
        int  stall_pct;
        int  phase_left;
        int  hold_left;
        bit  held_once;
        stall_pct  = 0;
        phase_left = 0;
        hold_left  = 0;
        held_once  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!held_once && results_seen >= 400) begin
                held_once = 1'b1;
                hold_left = 300;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        default: stall_pct = 60;
                    endcase
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        t_stim_row clr;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gen_fill     = 0;
        head_copy    = 0;
        fill_copy    = 0;
        offered      = dir_rows[0];
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.mode       <= MODE_CLEAR;
        cmd_ch.push_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) send_item(dir_rows[i]);

        gen_fill = 0;
        run_mix(300, 45, 30, 2);
        // Fill to capacity, then keep pushing against the full deque.
        while (gen_fill < DEPTH) send_random(pick_mode(92, 3, 0));
        run_mix(20, 80, 0, 0);
        run_mix(150, 50, 40, 0);
        run_mix(300, 5, 90, 0);
        clr.mode  = MODE_CLEAR;
        clr.value = pick_value();
        clr.typed = 1'b0;
        clr.want  = '0;
        send_item(clr);
        run_mix(300, 35, 35, 3);

        cmd_ch.valid <= 1'b0;
        // Let the last transfer reach the queue before draining it.
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
